// ===== rtl/sha1hs_pkg.sv =====
// SHA-1 stream hasher: shared types, constants and round functions.
// Used by the interface file, the round core and the top level.
// No dependencies.
package sha1hs_pkg;

	localparam int WORD_COUNT = 5;

	typedef logic [31:0] word_t;
	typedef word_t chain_t [WORD_COUNT];

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hefcdab89;
	localparam word_t IV2 = 32'h98badcfe;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hc3d2e1f0;

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LENGTH_AT  = 6'd56;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	typedef struct packed {
		logic init;
		logic load;
		logic round;
		logic fold;
	} core_ctl_t;

	function automatic word_t round_k(input logic [6:0] rnd);
		word_t k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic word_t round_f(input logic [6:0] rnd, input word_t b, input word_t c,
			input word_t d);
		word_t f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// ===== rtl/sha1hs_if.sv =====
// SHA-1 stream hasher: valid/ready channel interfaces for message bytes
// and digest words. Depends on sha1hs_pkg.
interface sha1hs_msg_if
	import sha1hs_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last_byte;

	modport source (output valid, data_byte, byte_present, last_byte, input ready);
	modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface sha1hs_digest_if
	import sha1hs_pkg::*;
();
	logic       valid;
	logic       ready;
	word_t      digest_word;
	logic [2:0] word_index;
	logic       last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha1_hash_stream.sv =====
// SHA-1 stream hasher, top level: block buffer and schedule shift line,
// padding sequencer and digest output. Depends on sha1hs_pkg, sha1hs_if,
// sha1hs_core and sha1hs_len_byte.
//
//  channel  dir  payload                                  transaction
//  msg      in   data_byte[7:0] byte_present last_byte    one byte or close mark
//  digest   out  digest_word[31:0] word_index[2:0] last_word  one digest word
//
// A byte is taken per cycle while msg.ready is high; each 64th byte starts a block
// compression (80 rounds on the shared round unit plus the chaining add). Closing a
// message adds 9 to 72 padding bytes and one or two compressions, then five digest
// transactions.
// msg.ready is low during a compression and from a close mark until the last
// digest transaction is taken.
// Reset restores the initial chaining words and clears the fill position and count.
module sha1_hash_stream
	import sha1hs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	sha1hs_msg_if.sink      msg,
	sha1hs_digest_if.source digest
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [1:0] PD_MARK = 2'd0;
	localparam logic [1:0] PD_ZERO = 2'd1;
	localparam logic [1:0] PD_LEN  = 2'd2;

	logic [2:0]   state_q;
	logic [1:0]   pad_q;
	logic         closing_q;
	logic [5:0]   fill_q;
	logic [60:0]  msg_q;
	logic [6:0]   rnd_q;
	logic [2:0]   idx_q;
	logic [511:0] buf_q;

	logic         in_acc;
	logic         out_acc;
	logic         put_en;
	logic [7:0]   put_val;
	logic         full;
	logic         is_len;
	logic [7:0]   len_byte;
	word_t        sched_new;
	word_t        w_word;
	core_ctl_t    ctl;
	chain_t       chain;

	assign msg.ready = (state_q == ST_IDLE);
	assign in_acc    = msg.valid && msg.ready;
	assign out_acc   = digest.valid && digest.ready;

	assign is_len = (pad_q == PD_LEN) || (pad_q == PD_ZERO && fill_q == LENGTH_AT);

	sha1hs_len_byte u_len (
		.msg_bytes (msg_q),
		.byte_sel  (fill_q[2:0]),
		.len_byte  (len_byte)
	);

	always_comb begin
		put_en  = 1'b0;
		put_val = msg.data_byte;
		case (state_q)
			ST_IDLE: begin
				put_en = in_acc && msg.byte_present;
			end
			ST_PAD: begin
				put_en = 1'b1;
				if (pad_q == PD_MARK) begin
					put_val = PAD_MARK;
				end else if (is_len) begin
					put_val = len_byte;
				end else begin
					put_val = 8'h00;
				end
			end
			default: begin
				put_en = 1'b0;
			end
		endcase
	end

	assign full = put_en && (fill_q == 6'd63);

	assign w_word    = buf_q[511:480];
	assign sched_new = {buf_q[94:64], buf_q[95]} ^ {buf_q[254:224], buf_q[255]}
		^ {buf_q[446:416], buf_q[447]} ^ {buf_q[510:480], buf_q[511]};

	always_comb begin
		ctl.init  = out_acc && (idx_q == 3'(WORD_COUNT - 1));
		ctl.load  = full;
		ctl.round = (state_q == ST_COMP);
		ctl.fold  = (state_q == ST_FOLD);
	end

	sha1hs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rnd    (rnd_q),
		.w_word (w_word),
		.chain  (chain)
	);

	always_ff @(posedge clk) begin
		if (put_en) begin
			buf_q <= {buf_q[503:0], put_val};
		end else if (state_q == ST_COMP) begin
			buf_q <= {buf_q[479:0], sched_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pad_q     <= PD_MARK;
			closing_q <= 1'b0;
			fill_q    <= '0;
			msg_q     <= '0;
			rnd_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (msg.byte_present) begin
							msg_q <= msg_q + 61'd1;
						end
						closing_q <= msg.last_byte;
						pad_q     <= PD_MARK;
						rnd_q     <= '0;
						if (full) begin
							state_q <= ST_COMP;
						end else if (msg.last_byte) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (pad_q == PD_MARK) begin
						pad_q <= PD_ZERO;
					end else if (is_len) begin
						pad_q <= PD_LEN;
					end
					rnd_q <= '0;
					if (full) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					idx_q <= '0;
					if (!closing_q) begin
						state_q <= ST_IDLE;
					end else if (pad_q == PD_LEN) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'(WORD_COUNT - 1)) begin
							msg_q     <= '0;
							fill_q    <= '0;
							closing_q <= 1'b0;
							pad_q     <= PD_MARK;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		case (idx_q)
			3'd0:    digest.digest_word = chain[0];
			3'd1:    digest.digest_word = chain[1];
			3'd2:    digest.digest_word = chain[2];
			3'd3:    digest.digest_word = chain[3];
			default: digest.digest_word = chain[4];
		endcase
	end

	assign digest.valid      = (state_q == ST_OUT);
	assign digest.word_index = idx_q;
	assign digest.last_word  = (idx_q == 3'(WORD_COUNT - 1));

endmodule

// ===== rtl/sha1hs_core.sv =====
// SHA-1 stream hasher: chaining words, working variables and the single
// round unit that runs one of the 80 rounds per cycle. Depends on sha1hs_pkg.
module sha1hs_core
	import sha1hs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctl_t  ctl,
	input  logic [6:0] rnd,
	input  word_t      w_word,
	output chain_t     chain
);

	chain_t chain_q;
	word_t  a_q, b_q, c_q, d_q, e_q;
	word_t  tmp;

	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(rnd, b_q, c_q, d_q) + e_q
		+ round_k(rnd) + w_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
			chain_q[4] <= IV4;
		end else if (ctl.init) begin
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
			chain_q[4] <= IV4;
		end else if (ctl.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctl.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign chain = chain_q;

endmodule

// ===== rtl/sha1hs_stream_top_note.sv =====
// SHA-1 stream hasher: byte selector for the length field.
// Selects one byte of the 64-bit message bit length. Depends on sha1hs_pkg.
module sha1hs_len_byte
	import sha1hs_pkg::*;
(
	input  logic [60:0] msg_bytes,
	input  logic [2:0]  byte_sel,
	output logic [7:0]  len_byte
);

	logic [63:0] bit_len;
	logic [63:0] shifted;

	assign bit_len  = {msg_bytes, 3'b000};
	assign shifted  = bit_len >> {~byte_sel, 3'b000};
	assign len_byte = shifted[7:0];

endmodule
